[sv/sfr_pkg.sv]
package sfr_pkg;

    // Window and replacement limits
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int JOB_BYTES       = 8;

    // Case folding constants
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Configuration register map
    typedef enum logic [2:0] {
        REG_PATTERN_BYTES      = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_BYTES  = 3'd2,
        REG_REPLACEMENT_LENGTH = 3'd3,
        REG_IGNORE_CASE        = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]  reg_index;
        logic [63:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } text_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       from_replacement;
        logic       run_last;
        logic       text_done;
    } result_item_t;

    // One burst of results from one input item
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [3:0]                count;  // 1 .. JOB_BYTES
        logic                      rep;    // bytes come from the replacement
        logic                      bare;   // single end marker, no byte
        logic                      done;   // burst closes the text
    } job_t;

endpackage

[sv/sfr_stream_if.sv]
interface sfr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

[sv/sfr_front.sv]
module sfr_front
    import sfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sfr_stream_if.sink   cfg,
    sfr_stream_if.sink   text,
    output logic         push,
    output job_t         push_job,
    input  logic         queue_full
);

    logic [63:0] pattern_bytes_reg;
    logic [3:0]  pattern_length_reg;
    logic [63:0] replacement_bytes_reg;
    logic [3:0]  replacement_length_reg;
    logic        ignore_case_reg;

    logic [7:0]  win_reg  [MAX_PATTERN];
    logic [7:0]  win_next [MAX_PATTERN];
    logic [3:0]  fill_reg;
    logic [3:0]  fill_next;

    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [3:0]  new_fill;
    logic [7:0]  w [MAX_PATTERN];
    logic        mismatch;
    logic        at_len;
    logic        over_len;
    logic        hit;
    logic        accept;
    logic        job_en;
    job_t        job;
    logic [7:0]  in_byte;
    logic        in_end;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        if (ic && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            return c + CASE_OFFSET;
        return c;
    endfunction

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= 4'd1;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
            ignore_case_reg        <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.payload.reg_index))
                REG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg.payload.data;
                REG_PATTERN_LENGTH:     pattern_length_reg     <= cfg.payload.data[3:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg.payload.data;
                REG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg.payload.data[3:0];
                REG_IGNORE_CASE:        ignore_case_reg        <= cfg.payload.data[0];
                default: ;
            endcase
        end
    end

    assign in_byte    = text.payload.text_byte;
    assign in_end     = text.payload.text_end;
    assign text.ready = !queue_full;
    assign accept     = text.valid && !queue_full;

    // Effective lengths
    always_comb
    begin
        if (pattern_length_reg == 4'd0)
            plen = 4'd1;
        else if (pattern_length_reg > 4'(MAX_PATTERN))
            plen = 4'(MAX_PATTERN);
        else
            plen = pattern_length_reg;

        if (replacement_length_reg > 4'(MAX_REPLACEMENT))
            rlen = 4'(MAX_REPLACEMENT);
        else
            rlen = replacement_length_reg;
    end

    // Window with the new byte appended, and the parallel compare
    always_comb
    begin
        new_fill = fill_reg + 4'd1;
        mismatch = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            w[i] = (4'(i) == fill_reg) ? in_byte : win_reg[i];
            if (4'(i) < plen &&
                fold(w[i], ignore_case_reg) !=
                fold(pattern_bytes_reg[8*i +: 8], ignore_case_reg))
                mismatch = 1'b1;
        end
        at_len   = (new_fill == plen);
        over_len = (new_fill > plen);
        hit      = at_len && !mismatch;
    end

    // Classify the item into a result burst and the next window
    always_comb
    begin
        job       = '0;
        job_en    = 1'b0;
        fill_next = new_fill;
        for (int i = 0; i < MAX_PATTERN; i++)
            win_next[i] = w[i];

        if (hit)
        begin
            fill_next = '0;
            if (rlen != 4'd0)
            begin
                job_en     = 1'b1;
                job.bytes  = replacement_bytes_reg;
                job.count  = rlen;
                job.rep    = 1'b1;
            end
            else if (in_end)
            begin
                job_en     = 1'b1;
                job.count  = 4'd1;
                job.bare   = 1'b1;
            end
        end
        else if (in_end || over_len)
        begin
            // Whole window goes out as plain text
            job_en    = 1'b1;
            job.count = new_fill;
            for (int i = 0; i < MAX_PATTERN; i++)
                job.bytes[i] = w[i];
            fill_next = '0;
        end
        else if (at_len)
        begin
            // No match: oldest byte out, window slides
            job_en       = 1'b1;
            job.count    = 4'd1;
            job.bytes[0] = w[0];
            fill_next    = plen - 4'd1;
            for (int i = 0; i < MAX_PATTERN - 1; i++)
                win_next[i] = w[i+1];
        end
        job.done = in_end;
    end

    assign push     = accept && job_en;
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (accept)
            fill_reg <= fill_next;
    end

    // Window bytes need no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
                win_reg[i] <= win_next[i];
        end
    end

endmodule

[sv/sfr_job_queue.sv]
module sfr_job_queue
    import sfr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[sv/sfr_back.sv]
module sfr_back
    import sfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  job_t         head,
    input  logic         empty,
    output logic         pop,
    sfr_stream_if.source result
);

    job_t       job_reg;
    logic       busy_reg;
    logic       busy_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       last;
    logic       fire;
    logic       load;

    assign last = ({1'b0, idx_reg} == job_reg.count - 4'd1);
    assign fire = busy_reg && result.ready;
    assign load = !busy_reg || (fire && last);
    assign pop  = load && !empty;

    // Burst sequencing
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = !empty;
            idx_next  = '0;
        end
        else if (fire)
            idx_next = idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head;
    end

    // Result fields
    assign result.valid                    = busy_reg;
    assign result.payload.out_byte         = job_reg.bytes[idx_reg];
    assign result.payload.out_valid        = !job_reg.bare;
    assign result.payload.from_replacement = job_reg.rep;
    assign result.payload.run_last         = last;
    assign result.payload.text_done        = job_reg.done && last;

endmodule

[sv/stream_find_and_replace_core.sv]
// Channel  Direction  Payload                                       Transfer
// cfg      in         reg_index[2:0], data[63:0]                    valid && ready
// text     in         text_byte[7:0], text_end                      valid && ready
// result   out        out_byte[7:0], out_valid, from_replacement,   valid && ready
//                     run_last, text_done
//
// One text byte is taken per cycle while the queue has room; the window
// compare is combinational. An item with n results sends them as a burst,
// one per cycle while result is ready; a queue of QUEUE_DEPTH bursts sits
// between the sides. text stalls only when it is full; cfg is always ready.
// Reset clears configuration to its defaults and empties window and queue.
module stream_find_and_replace_core
    import sfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    sfr_stream_if.sink   cfg,
    sfr_stream_if.sink   text,
    sfr_stream_if.source result
);

    logic push;
    job_t push_job;
    logic pop;
    job_t head;
    logic full;
    logic empty;

    // Window, compare and burst classification
    sfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .text       (text),
        .push       (push),
        .push_job   (push_job),
        .queue_full (full)
    );

    // Burst queue
    sfr_job_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    // Burst serializer
    sfr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule
